// ===== hw/rtl/clbs_pkg.sv =====
// clbs_pkg: shared types, codes and scan tables for the charlieplexed led bar scanner
// no dependencies; used by the channel interfaces and the core
`default_nettype none

package clbs_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned LevelW = 3;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DriveW = 2;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DataW-1:0] ThrOneRst   = 8'd16;
  localparam logic [DataW-1:0] ThrTwoRst   = 8'd37;
  localparam logic [DataW-1:0] ThrThreeRst = 8'd58;
  localparam logic [DataW-1:0] ThrFourRst  = 8'd79;
  localparam logic [DataW-1:0] StepLimRst  = 8'd50;

  localparam logic [LevelW-1:0] LevelMin  = 3'd1;
  localparam logic [LevelW-1:0] LevelMax  = 3'd5;
  localparam logic [LevelW-1:0] LevelNone = 3'd0;
  localparam logic [PhaseW-1:0] PhaseLast = 3'd4;

  typedef enum logic [FuncW-1:0] {
    FUNC_CAP_UPDATE = 2'd0,
    FUNC_START_ON   = 2'd1,
    FUNC_START_OFF  = 2'd2,
    FUNC_SCAN_TICK  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR_ONE    = 3'd0,
    CFG_THR_TWO    = 3'd1,
    CFG_THR_THREE  = 3'd2,
    CFG_THR_FOUR   = 3'd3,
    CFG_STEP_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [DriveW-1:0] {
    DRV_LOW   = 2'd0,
    DRV_HIGH  = 2'd1,
    DRV_FLOAT = 2'd2
  } drive_e;

  typedef enum logic [2:0] {
    PAT_LOW = 3'd0,
    PAT_L5  = 3'd1,
    PAT_L4  = 3'd2,
    PAT_L34 = 3'd3,
    PAT_L2  = 3'd4,
    PAT_L12 = 3'd5
  } pat_e;

  typedef struct packed {
    drive_e pin_one;
    drive_e pin_two;
    drive_e pin_three;
  } pins_t;

  typedef struct packed {
    pins_t             pins;
    logic [LevelW-1:0] level_shown;
    logic              capacity_active;
    logic              light_on_active;
    logic              light_off_active;
  } out_item_t;

  // pattern for a given bar level and scan phase
  function automatic pat_e scan_pattern(logic [LevelW-1:0] level, logic [PhaseW-1:0] phase);
    pat_e pat;
    pat = PAT_LOW;
    case (phase)
      3'd0: if (level >= 3'd1 && level <= 3'd5) pat = PAT_L5;
      3'd1: begin
        case (level)
          3'd2:      pat = PAT_L4;
          3'd3, 3'd4, 3'd5: pat = PAT_L34;
          default:   pat = PAT_LOW;
        endcase
      end
      3'd2: begin
        case (level)
          3'd1, 3'd2, 3'd3: pat = PAT_L5;
          3'd4:      pat = PAT_L2;
          3'd5:      pat = PAT_L12;
          default:   pat = PAT_LOW;
        endcase
      end
      3'd3: begin
        case (level)
          3'd2:       pat = PAT_L4;
          3'd3:       pat = PAT_L34;
          3'd4, 3'd5: pat = PAT_L5;
          default:    pat = PAT_LOW;
        endcase
      end
      3'd4: begin
        case (level)
          3'd1, 3'd2, 3'd3: pat = PAT_L5;
          3'd4, 3'd5: pat = PAT_L34;
          default:    pat = PAT_LOW;
        endcase
      end
      default: pat = PAT_LOW;
    endcase
    return pat;
  endfunction

  function automatic pins_t pattern_pins(pat_e pat);
    pins_t p;
    case (pat)
      PAT_L5:  p = '{pin_one: DRV_HIGH,  pin_two: DRV_FLOAT, pin_three: DRV_LOW};
      PAT_L4:  p = '{pin_one: DRV_FLOAT, pin_two: DRV_HIGH,  pin_three: DRV_LOW};
      PAT_L34: p = '{pin_one: DRV_LOW,   pin_two: DRV_HIGH,  pin_three: DRV_LOW};
      PAT_L2:  p = '{pin_one: DRV_FLOAT, pin_two: DRV_LOW,   pin_three: DRV_HIGH};
      PAT_L12: p = '{pin_one: DRV_HIGH,  pin_two: DRV_LOW,   pin_three: DRV_HIGH};
      default: p = '{pin_one: DRV_LOW,   pin_two: DRV_LOW,   pin_three: DRV_LOW};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clbs_if.sv =====
// clbs channel interfaces: command items, result items and register writes
// depends on clbs_pkg for field widths
`default_nettype none

interface clbs_cmd_if
  import clbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [DataW-1:0]  capacity;
  logic              display_enable;

  modport source (output valid, output func, output capacity, output display_enable,
                  input ready);
  modport sink   (input valid, input func, input capacity, input display_enable,
                  output ready);
endinterface

interface clbs_res_if
  import clbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DriveW-1:0] pin_one_drive;
  logic [DriveW-1:0] pin_two_drive;
  logic [DriveW-1:0] pin_three_drive;
  logic [LevelW-1:0] level_shown;
  logic              capacity_active;
  logic              light_on_active;
  logic              light_off_active;

  modport source (output valid, output pin_one_drive, output pin_two_drive,
                  output pin_three_drive, output level_shown, output capacity_active,
                  output light_on_active, output light_off_active, input ready);
  modport sink   (input valid, input pin_one_drive, input pin_two_drive,
                  input pin_three_drive, input level_shown, input capacity_active,
                  input light_on_active, input light_off_active, output ready);
endinterface

interface clbs_cfg_if
  import clbs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/charlieplexed_led_bar_scanner_core.sv =====
// charlieplexed led bar scanner core: level mapping, animations and pin scan
// the result of an accepted item is registered in the output register
// throughput: one item per cycle while the result side is ready; the single output register is reloaded as it drains
// reset: thresholds 16/37/58/79, step limit 50, phase and counter zero, all modes off
// depends on clbs_pkg and the channel interfaces in clbs_if.sv
`default_nettype none

module charlieplexed_led_bar_scanner_core
  import clbs_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  clbs_cmd_if.sink    in_i,
  clbs_res_if.source  out_o,
  clbs_cfg_if.sink    cfg_i
);

  logic [DataW-1:0] thr_one_q, thr_two_q, thr_three_q, thr_four_q, step_limit_q;

  logic [PhaseW-1:0] scan_phase_q, scan_phase_d;
  logic [DataW-1:0]  step_count_q, step_count_d;
  logic [LevelW-1:0] cap_level_q, cap_level_d;
  logic [LevelW-1:0] on_level_q, on_level_d;
  logic [LevelW-1:0] off_level_q, off_level_d;
  logic              cap_mode_q, cap_mode_d;
  logic              on_mode_q, on_mode_d;
  logic              off_mode_q, off_mode_d;

  out_item_t out_q, out_d;
  logic      out_valid_q;

  logic              in_fire, cfg_fire;
  func_e             func;
  logic [DataW:0]    step_next;
  logic              step_due;
  logic [LevelW-1:0] cap_map, level;
  logic              show;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign func        = func_e'(in_i.func);

  // shared animation tick counter, one bit wider so a limit of 255 still wraps
  assign step_next = {1'b0, step_count_q} + {{DataW{1'b0}}, 1'b1};
  assign step_due  = step_next > {1'b0, step_limit_q};

  always_comb begin
    if (in_i.capacity <= thr_one_q)        cap_map = 3'd1;
    else if (in_i.capacity <= thr_two_q)   cap_map = 3'd2;
    else if (in_i.capacity <= thr_three_q) cap_map = 3'd3;
    else if (in_i.capacity <= thr_four_q)  cap_map = 3'd4;
    else                                   cap_map = LevelMax;
  end

  always_comb begin
    scan_phase_d = scan_phase_q;
    step_count_d = step_count_q;
    cap_level_d  = cap_level_q;
    on_level_d   = on_level_q;
    off_level_d  = off_level_q;
    cap_mode_d   = cap_mode_q;
    on_mode_d    = on_mode_q;
    off_mode_d   = off_mode_q;
    level        = LevelNone;
    show         = 1'b0;

    case (func)
      FUNC_CAP_UPDATE: begin
        if (in_i.display_enable) begin
          cap_level_d = cap_map;
          cap_mode_d  = 1'b1;
        end else begin
          cap_mode_d  = 1'b0;
        end
      end
      FUNC_START_ON: begin
        if (!on_mode_q) begin
          on_level_d = LevelMin;
          on_mode_d  = 1'b1;
        end
      end
      FUNC_START_OFF: begin
        if (!off_mode_q) begin
          off_level_d = LevelMax;
          off_mode_d  = 1'b1;
        end
      end
      default: begin
        if (off_mode_q) begin
          if (off_level_q != LevelNone) begin
            level        = off_level_q;
            show         = 1'b1;
            step_count_d = step_due ? '0 : step_next[DataW-1:0];
            if (step_due) off_level_d = off_level_q - 3'd1;
          end else begin
            off_mode_d = 1'b0;
          end
        end else if (on_mode_q) begin
          if (on_level_q <= LevelMax) begin
            level        = on_level_q;
            show         = 1'b1;
            step_count_d = step_due ? '0 : step_next[DataW-1:0];
            if (step_due) on_level_d = on_level_q + 3'd1;
          end else begin
            on_mode_d = 1'b0;
          end
        end else if (cap_mode_q) begin
          level = cap_level_q;
          show  = 1'b1;
        end
      end
    endcase

    if (show) begin
      scan_phase_d = (scan_phase_q >= PhaseLast) ? '0 : scan_phase_q + 3'd1;
    end

    out_d.pins             = pattern_pins(show ? scan_pattern(level, scan_phase_q) : PAT_LOW);
    out_d.level_shown      = level;
    out_d.capacity_active  = cap_mode_d;
    out_d.light_on_active  = on_mode_d;
    out_d.light_off_active = off_mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_one_q    <= ThrOneRst;
      thr_two_q    <= ThrTwoRst;
      thr_three_q  <= ThrThreeRst;
      thr_four_q   <= ThrFourRst;
      step_limit_q <= StepLimRst;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_THR_ONE:    thr_one_q    <= cfg_i.data;
        CFG_THR_TWO:    thr_two_q    <= cfg_i.data;
        CFG_THR_THREE:  thr_three_q  <= cfg_i.data;
        CFG_THR_FOUR:   thr_four_q   <= cfg_i.data;
        CFG_STEP_LIMIT: step_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_phase_q <= '0;
      step_count_q <= '0;
      cap_level_q  <= LevelNone;
      on_level_q   <= LevelMin;
      off_level_q  <= LevelMax;
      cap_mode_q   <= 1'b0;
      on_mode_q    <= 1'b0;
      off_mode_q   <= 1'b0;
    end else if (in_fire) begin
      scan_phase_q <= scan_phase_d;
      step_count_q <= step_count_d;
      cap_level_q  <= cap_level_d;
      on_level_q   <= on_level_d;
      off_level_q  <= off_level_d;
      cap_mode_q   <= cap_mode_d;
      on_mode_q    <= on_mode_d;
      off_mode_q   <= off_mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= out_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pin_one_drive    = out_q.pins.pin_one;
  assign out_o.pin_two_drive    = out_q.pins.pin_two;
  assign out_o.pin_three_drive  = out_q.pins.pin_three;
  assign out_o.level_shown      = out_q.level_shown;
  assign out_o.capacity_active  = out_q.capacity_active;
  assign out_o.light_on_active  = out_q.light_on_active;
  assign out_o.light_off_active = out_q.light_off_active;

`ifndef SYNTHESIS
  // an accepted item always leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item left no result");

  // scan phase and animation state move only on accepted items
  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(scan_phase_q) && $stable(step_count_q) && $stable(on_level_q)
                 && $stable(off_level_q))
    else $error("scan state changed without an item");

  // a non-tick item shows nothing and drives all pins low
  a_non_tick_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (func != FUNC_SCAN_TICK) |=>
      (out_q.level_shown == LevelNone) && (out_q.pins.pin_one == DRV_LOW)
      && (out_q.pins.pin_two == DRV_LOW) && (out_q.pins.pin_three == DRV_LOW))
    else $error("non-tick item lit the bar");

  // a light-on start command leaves its animation running
  a_start_on_sets_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (func == FUNC_START_ON) |=> on_mode_q && out_q.light_on_active)
    else $error("light-on start did not take");

  // phase stays inside the five-slot scan
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && show |=> (scan_phase_q <= PhaseLast) && (out_q.level_shown <= LevelMax))
    else $error("scan phase or level out of range");
`endif

endmodule

`default_nettype wire

// ===== test/charlieplexed_led_bar_scanner_core_checker.sv =====
// result checker for the charlieplexed led bar scanner core: tracks register writes,
// predicts one result per command item and compares the result channel in order
// depends on clbs_pkg and the channel interfaces in clbs_if.sv
`timescale 1ns / 1ps

module charlieplexed_led_bar_scanner_core_checker
  import clbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  clbs_cmd_if  cmd_i,
  clbs_res_if  res_i,
  clbs_cfg_if  cfg_i,
  output int   open_results_o,
  output int   mismatch_count_o
);

  logic [DataW-1:0]  thr_one, thr_two, thr_three, thr_four, step_lim;
  logic [PhaseW-1:0] scan_ph;
  logic [DataW-1:0]  tick_cnt;
  logic [LevelW-1:0] bar_cap, rise_lvl, fall_lvl;
  logic              cap_on, rise_on, fall_on;

  out_item_t expected_scans[$];
  out_item_t want;
  int        errors;

  assign mismatch_count_o = errors;

  // shared animation counter; compare is one bit wider so a limit of 255 still steps
  function automatic logic step_due();
    logic [DataW:0] nxt;
    nxt = {1'b0, tick_cnt} + 1'b1;
    if (nxt > {1'b0, step_lim}) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = nxt[DataW-1:0];
    return 1'b0;
  endfunction

  function automatic pins_t lit_pins(logic [LevelW-1:0] lvl, logic [PhaseW-1:0] ph);
    pat_e  pat;
    pins_t p;
    case (lvl)
      3'd1: pat = ph[0] ? PAT_LOW : PAT_L5;
      3'd2: pat = ph[0] ? PAT_L4 : PAT_L5;
      3'd3: pat = ph[0] ? PAT_L34 : PAT_L5;
      3'd4, 3'd5: begin
        case (ph)
          3'd0, 3'd3: pat = PAT_L5;
          3'd1, 3'd4: pat = PAT_L34;
          3'd2:       pat = (lvl == 3'd4) ? PAT_L2 : PAT_L12;
          default:    pat = PAT_LOW;
        endcase
      end
      default: pat = PAT_LOW;
    endcase
    case (pat)
      PAT_L5:  p = '{DRV_HIGH, DRV_FLOAT, DRV_LOW};
      PAT_L4:  p = '{DRV_FLOAT, DRV_HIGH, DRV_LOW};
      PAT_L34: p = '{DRV_LOW, DRV_HIGH, DRV_LOW};
      PAT_L2:  p = '{DRV_FLOAT, DRV_LOW, DRV_HIGH};
      PAT_L12: p = '{DRV_HIGH, DRV_LOW, DRV_HIGH};
      default: p = '{DRV_LOW, DRV_LOW, DRV_LOW};
    endcase
    return p;
  endfunction

  function automatic out_item_t bar_scan(func_e f, logic [DataW-1:0] cap, logic en);
    out_item_t r;
    logic [LevelW-1:0] lvl;
    logic lit;
    lvl = LevelNone;
    lit = 1'b0;
    case (f)
      FUNC_CAP_UPDATE: begin
        if (en) begin
          if (cap <= thr_one) bar_cap = 3'd1;
          else if (cap <= thr_two) bar_cap = 3'd2;
          else if (cap <= thr_three) bar_cap = 3'd3;
          else if (cap <= thr_four) bar_cap = 3'd4;
          else bar_cap = 3'd5;
          cap_on = 1'b1;
        end else begin
          cap_on = 1'b0;
        end
      end
      FUNC_START_ON: begin
        if (!rise_on) begin
          rise_lvl = LevelMin;
          rise_on = 1'b1;
        end
      end
      FUNC_START_OFF: begin
        if (!fall_on) begin
          fall_lvl = LevelMax;
          fall_on = 1'b1;
        end
      end
      default: begin
        // light-off wins over light-on, light-on over capacity
        if (fall_on) begin
          if (fall_lvl != LevelNone) begin
            lvl = fall_lvl;
            lit = 1'b1;
            if (step_due()) fall_lvl = fall_lvl - 1'b1;
          end else begin
            fall_on = 1'b0;
          end
        end else if (rise_on) begin
          if (rise_lvl <= LevelMax) begin
            lvl = rise_lvl;
            lit = 1'b1;
            if (step_due()) rise_lvl = rise_lvl + 1'b1;
          end else begin
            rise_on = 1'b0;
          end
        end else if (cap_on) begin
          lvl = bar_cap;
          lit = 1'b1;
        end
      end
    endcase
    r.pins = '{DRV_LOW, DRV_LOW, DRV_LOW};
    if (lit) begin
      r.pins = lit_pins(lvl, scan_ph);
      scan_ph = (scan_ph >= PhaseLast) ? '0 : scan_ph + 1'b1;
    end
    r.level_shown      = lvl;
    r.capacity_active  = cap_on;
    r.light_on_active  = rise_on;
    r.light_off_active = fall_on;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
    if (got !== exp_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_one   = ThrOneRst;
      thr_two   = ThrTwoRst;
      thr_three = ThrThreeRst;
      thr_four  = ThrFourRst;
      step_lim  = StepLimRst;
      scan_ph   = '0;
      tick_cnt  = '0;
      bar_cap   = LevelNone;
      rise_lvl  = LevelMin;
      fall_lvl  = LevelMax;
      cap_on    = 1'b0;
      rise_on   = 1'b0;
      fall_on   = 1'b0;
      expected_scans.delete();
      open_results_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_THR_ONE:    thr_one = cfg_i.data;
          CFG_THR_TWO:    thr_two = cfg_i.data;
          CFG_THR_THREE:  thr_three = cfg_i.data;
          CFG_THR_FOUR:   thr_four = cfg_i.data;
          CFG_STEP_LIMIT: step_lim = cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready)
        expected_scans.push_back(bar_scan(func_e'(cmd_i.func), cmd_i.capacity,
                                          cmd_i.display_enable));
      if (res_i.valid && res_i.ready) begin
        if (expected_scans.size() == 0) begin
          $display("%0t: result item with nothing outstanding", $time);
          errors++;
        end else begin
          want = expected_scans.pop_front();
          check_field("pin_one_drive", 8'(want.pins.pin_one), 8'(res_i.pin_one_drive));
          check_field("pin_two_drive", 8'(want.pins.pin_two), 8'(res_i.pin_two_drive));
          check_field("pin_three_drive", 8'(want.pins.pin_three),
                      8'(res_i.pin_three_drive));
          check_field("level_shown", 8'(want.level_shown), 8'(res_i.level_shown));
          check_field("capacity_active", 8'(want.capacity_active),
                      8'(res_i.capacity_active));
          check_field("light_on_active", 8'(want.light_on_active),
                      8'(res_i.light_on_active));
          check_field("light_off_active", 8'(want.light_off_active),
                      8'(res_i.light_off_active));
        end
      end
      open_results_o <= expected_scans.size();
    end
  end

endmodule

// ===== test/charlieplexed_led_bar_scanner_core_test.sv =====
// top of the charlieplexed led bar scanner core testbench: clock, reset, command and
// register stimulus, result back-pressure and the verdict
// depends on clbs_pkg, clbs_if.sv, the core and charlieplexed_led_bar_scanner_core_checker
`timescale 1ns / 1ps

module charlieplexed_led_bar_scanner_core_test;
  import clbs_pkg::*;

  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  clbs_cmd_if cmd_ch ();
  clbs_res_if res_ch ();
  clbs_cfg_if cfg_ch ();

  int open_results;
  int mismatches;
  int tx_idle_pct = 26;
  int rx_idle_pct = 75;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  charlieplexed_led_bar_scanner_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  charlieplexed_led_bar_scanner_core_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_ch),
    .res_i            (res_ch),
    .cfg_i            (cfg_ch),
    .open_results_o   (open_results),
    .mismatch_count_o (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic put_cmd(input func_e f, input logic [DataW-1:0] cap, input logic en);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.func           <= f;
    cmd_ch.capacity       <= cap;
    cmd_ch.display_enable <= en;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  // stop offering items and wait for every outstanding result
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [DataW-1:0] t1, input logic [DataW-1:0] t2,
                            input logic [DataW-1:0] t3, input logic [DataW-1:0] t4,
                            input logic [DataW-1:0] lim);
    cfg_idx_e         regs[5] = '{CFG_THR_ONE, CFG_THR_TWO, CFG_THR_THREE, CFG_THR_FOUR,
                                  CFG_STEP_LIMIT};
    logic [DataW-1:0] vals[5];
    vals = '{t1, t2, t3, t4, lim};
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[k];
      cfg_ch.data  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly scan ticks so animations run to their end, the rest commands with random content
  task automatic run_random(input int count, input int tick_pct, input int pause_at);
    int    pick;
    func_e f;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      pick = $urandom_range(99);
      if (pick < tick_pct) f = FUNC_SCAN_TICK;
      else f = func_e'(pick % 3);
      put_cmd(f, 8'($urandom_range(255)), $urandom_range(9) < 8);
    end
  endtask

  initial begin
    logic [DataW-1:0] thr_q[$];
    rst_ni                <= 1'b0;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.func           <= FUNC_CAP_UPDATE;
    cmd_ch.capacity       <= '0;
    cmd_ch.display_enable <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_THR_ONE;
    cfg_ch.data           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: threshold boundaries, display off, idle tick, repeated starts
    put_cmd(FUNC_SCAN_TICK, 8'd255, 1'b1);
    put_cmd(FUNC_CAP_UPDATE, 8'd0, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd16, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd17, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd58, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd79, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd80, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd255, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd255, 1'b0);
    put_cmd(FUNC_SCAN_TICK, 8'd255, 1'b1);
    put_cmd(FUNC_START_ON, 8'd255, 1'b0);
    put_cmd(FUNC_START_ON, 8'd0, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);
    put_cmd(FUNC_START_OFF, 8'd170, 1'b1);
    put_cmd(FUNC_SCAN_TICK, 8'd85, 1'b0);
    put_cmd(FUNC_CAP_UPDATE, 8'd37, 1'b1);
    put_cmd(FUNC_START_OFF, 8'd0, 1'b0);
    put_cmd(FUNC_SCAN_TICK, 8'd0, 1'b0);

    // lowest thresholds and fast stepping: animations run to their end often
    settle();
    write_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    run_random(25, 60, -1);

    // highest thresholds and slowest stepping, long tick runs past 256
    settle();
    write_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(280, 95, -1);

    tx_idle_pct = 75;
    rx_idle_pct = 26;
    settle();
    repeat (4) thr_q.push_back(8'($urandom_range(255)));
    thr_q.sort();
    write_regs(thr_q[0], thr_q[1], thr_q[2], thr_q[3], 8'($urandom_range(8, 1)));
    run_random(25, 60, -1);

    // unordered thresholds, with a pause until all results are in
    settle();
    write_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'd2);
    run_random(25, 60, 12);

    // no idling, and a long receiver hold-off that backs up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    write_regs(ThrOneRst, ThrTwoRst, ThrThreeRst, ThrFourRst, 8'd3);
    hold_req = 1'b1;
    run_random(25, 60, -1);

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
